// ===== rtl/rwlc_pkg.sv =====
// Shared types, constants and divide helpers for the rain wheel LED color block.
`timescale 1ns / 1ps

package rwlc_pkg;

    // Field widths
    localparam int LED_W   = 7;
    localparam int HOUR_W  = 4;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int HUND_W  = 7;
    localparam int LEVEL_W = 8;

    // Ring geometry
    localparam logic [6:0]  INNER_COUNT = 7'd24;   // LEDs 0..23 are the inner ring
    localparam logic [5:0]  HOUR_WRAP   = 6'd12;   // hour position that folds back to 0
    localparam logic [6:0]  BOTTOM_POS  = 7'd30;   // bottom LED of the outer ring

    // Inner ramp
    localparam logic [10:0] RAMP_BASE   = 11'd480;
    localparam logic [10:0] RAMP_PERIOD = 11'd240;
    localparam logic [7:0]  RAMP_RISE   = 8'd80;
    localparam logic [7:0]  RAMP_FALL   = 8'd160;
    localparam logic [7:0]  SCALE_MIN   = 8'd8;

    // Top LED: 5*b/15 == b/3
    localparam logic [6:0]  TOP_FACTOR  = 7'd5;

    // Reciprocal multipliers, exact over the ranges used here
    localparam logic [15:0] DIV5_MUL    = 16'd52429;   // ceil(2^18 / 5)
    localparam logic [15:0] DIV15_MUL   = 16'd34953;   // ceil(2^19 / 15)

    localparam logic [7:0]  BRIGHT_RESET = 8'd128;

    // Color class of one LED, decided in the classify stage
    typedef enum logic [2:0] {
        CLS_HOUR,
        CLS_RAMP,
        CLS_MINUTE,
        CLS_TOP,
        CLS_BOTTOM,
        CLS_SIDE
    } cls_t;

    // x / 5 for x < 2^18 (x is 11 bits here)
    function automatic logic [8:0] div5(input logic [10:0] x);
        logic [26:0] prod;
        prod = 27'(x) * 27'(DIV5_MUL);
        return prod[26:18];
    endfunction

    // x / 15 for x < 2^15, when the quotient fits in 8 bits
    function automatic logic [7:0] div15(input logic [14:0] x);
        logic [30:0] prod;
        prod = 31'(x) * 31'(DIV15_MUL);
        return prod[26:19];
    endfunction

endpackage

// ===== rtl/rwlc_pix_if.sv =====
// Input channel: one LED index plus the current time per word.
`timescale 1ns / 1ps

interface rwlc_pix_if;
    logic       valid;
    logic       ready;
    logic [6:0] led_index;
    logic [3:0] hour_now;
    logic [5:0] minute_now;
    logic [5:0] second_now;
    logic [6:0] hundredths_now;

    modport source (output valid, led_index, hour_now, minute_now, second_now,
                    hundredths_now, input ready);
    modport sink   (input valid, led_index, hour_now, minute_now, second_now,
                    hundredths_now, output ready);
endinterface

// ===== rtl/rwlc_color_if.sv =====
// Output channel: one RGB color per word.
`timescale 1ns / 1ps

interface rwlc_color_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;

    modport source (output valid, red_level, green_level, blue_level, input ready);
    modport sink   (input valid, red_level, green_level, blue_level, output ready);
endinterface

// ===== rtl/rwlc_cfg_if.sv =====
// Configuration write channel: brightness register data.
`timescale 1ns / 1ps

interface rwlc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] brightness_level;

    modport source (output valid, brightness_level, input ready);
    modport sink   (input valid, brightness_level, output ready);
endinterface

// ===== rtl/rwlc_datapath.sv =====
// Four-register color datapath: input, classify, multiply, divide and output.
`timescale 1ns / 1ps

module rwlc_datapath (
    input  logic       clk,
    input  logic       en,
    input  logic [6:0] led_index,
    input  logic [3:0] hour_now,
    input  logic [5:0] minute_now,
    input  logic [5:0] second_now,
    input  logic [6:0] hundredths_now,
    input  logic [7:0] brightness,
    output logic [7:0] red_level,
    output logic [7:0] green_level,
    output logic [7:0] blue_level
);

    // Stage 1: input register
    logic [6:0] led_reg;
    logic [3:0] hour_reg;
    logic [5:0] minute_reg;
    logic [5:0] second_reg;
    logic [6:0] hund_reg;

    // Stage 2: class, floor and multiplier factor
    rwlc_pkg::cls_t cls2_reg, cls2_next;
    logic [1:0]     floor2_reg, floor2_next;
    logic [6:0]     factor_reg, factor_next;

    // Stage 3: class, floor and product
    rwlc_pkg::cls_t cls3_reg;
    logic [1:0]     floor3_reg;
    logic [14:0]    prod_reg, prod_next;

    // Output register
    logic [7:0] red_reg, red_next;
    logic [7:0] green_reg, green_next;
    logic [7:0] blue_reg, blue_next;

    // Stage 1 intermediates
    logic        inner;
    logic [6:0]  led_p1;
    logic [5:0]  hour_pos;
    logic [5:0]  hour_pos_w;
    logic        hour_hit;
    logic [10:0] hund_x12;
    logic [8:0]  ramp_shift;
    logic [10:0] led_x10;
    logic [10:0] ramp_sum;
    logic [10:0] ramp_mod;
    logic [7:0]  ramp_pos;
    logic [6:0]  ramp_num;
    logic [6:0]  outer_pos;
    logic [8:0]  fall_step;
    logic [1:0]  side_step;
    logic [6:0]  side_factor;

    // Stage 2/3 intermediates
    logic        is_ramp2;
    logic [7:0]  scale;
    logic [7:0]  mul_a;
    logic [14:0] dividend;
    logic [7:0]  quot;
    logic [7:0]  floor_lvl;
    logic [7:0]  min_white;

    // Input register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            led_reg    <= led_index;
            hour_reg   <= hour_now;
            minute_reg <= minute_now;
            second_reg <= second_now;
            hund_reg   <= hundredths_now;
        end
    end

    // Classify the LED and work out the ramp position
    always_comb
    begin
        inner      = led_reg < rwlc_pkg::INNER_COUNT;
        led_p1     = led_reg + 7'd1;
        hour_pos   = led_p1[6:1];
        hour_pos_w = (hour_pos == rwlc_pkg::HOUR_WRAP) ? 6'd0 : hour_pos;
        hour_hit   = hour_pos_w == {2'b00, hour_reg};

        // ramp position = (480 + 10*led - 24*hund/10) mod 240
        hund_x12   = ({4'b0000, hund_reg} << 3) + ({4'b0000, hund_reg} << 2);
        ramp_shift = rwlc_pkg::div5(hund_x12);
        led_x10    = ({4'b0000, led_reg} << 3) + ({4'b0000, led_reg} << 1);
        ramp_sum   = rwlc_pkg::RAMP_BASE + led_x10 - {2'b00, ramp_shift};
        if (ramp_sum >= rwlc_pkg::RAMP_BASE)
            ramp_mod = ramp_sum - rwlc_pkg::RAMP_BASE;
        else if (ramp_sum >= rwlc_pkg::RAMP_PERIOD)
            ramp_mod = ramp_sum - rwlc_pkg::RAMP_PERIOD;
        else
            ramp_mod = ramp_sum;
        ramp_pos = ramp_mod[7:0];

        // rising edge, falling edge, or dark tail (zero lifts to the floor of 1)
        if (ramp_pos < rwlc_pkg::RAMP_RISE)
            ramp_num = ramp_pos[6:0];
        else if (ramp_pos < rwlc_pkg::RAMP_FALL)
            ramp_num = 7'(rwlc_pkg::RAMP_FALL - ramp_pos);
        else
            ramp_num = 7'd0;

        // outer ring: four-step pattern, direction depends on the side
        outer_pos = led_reg - rwlc_pkg::INNER_COUNT;
        fall_step = rwlc_pkg::div5({4'b0000, hund_reg});
        if (outer_pos < rwlc_pkg::BOTTOM_POS)
            side_step = outer_pos[1:0] - fall_step[1:0];
        else
            side_step = outer_pos[1:0] + fall_step[1:0];
        side_factor = {5'b00000, side_step} + 7'd1;

        floor2_next = (outer_pos == {1'b0, second_reg}) ? 2'd2 : 2'd1;

        if (inner)
        begin
            cls2_next   = hour_hit ? rwlc_pkg::CLS_HOUR : rwlc_pkg::CLS_RAMP;
            factor_next = ramp_num;
        end
        else if (outer_pos == {1'b0, minute_reg})
        begin
            cls2_next   = rwlc_pkg::CLS_MINUTE;
            factor_next = side_factor;
        end
        else if (outer_pos == 7'd0)
        begin
            cls2_next   = rwlc_pkg::CLS_TOP;
            factor_next = rwlc_pkg::TOP_FACTOR;
        end
        else if (outer_pos == rwlc_pkg::BOTTOM_POS)
        begin
            cls2_next   = rwlc_pkg::CLS_BOTTOM;
            factor_next = side_factor;
        end
        else
        begin
            cls2_next   = rwlc_pkg::CLS_SIDE;
            factor_next = side_factor;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cls2_reg   <= cls2_next;
            floor2_reg <= floor2_next;
            factor_reg <= factor_next;
        end
    end

    // Shared multiplier: ramp uses max(8,b), the outer ring uses b
    always_comb
    begin
        is_ramp2  = cls2_reg == rwlc_pkg::CLS_RAMP;
        scale     = (brightness > rwlc_pkg::SCALE_MIN) ? brightness : rwlc_pkg::SCALE_MIN;
        mul_a     = is_ramp2 ? scale : brightness;
        prod_next = 15'({7'b0000000, mul_a} * {8'b00000000, factor_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cls3_reg   <= cls2_reg;
            floor3_reg <= floor2_reg;
            prod_reg   <= prod_next;
        end
    end

    // Divide by 240 (ramp) or 15 (outer ring) and apply the floors
    always_comb
    begin
        dividend  = (cls3_reg == rwlc_pkg::CLS_RAMP) ? {4'b0000, prod_reg[14:4]} : prod_reg;
        quot      = rwlc_pkg::div15(dividend);
        floor_lvl = {6'b000000, floor3_reg};
        min_white = (brightness == 8'd0) ? 8'd1 : brightness;

        red_next   = 8'd0;
        green_next = 8'd0;
        blue_next  = 8'd0;
        unique case (cls3_reg) inside
            rwlc_pkg::CLS_HOUR:
            begin
                red_next   = brightness;
                green_next = brightness;
                blue_next  = brightness;
            end
            rwlc_pkg::CLS_MINUTE:
            begin
                red_next   = min_white;
                green_next = min_white;
                blue_next  = min_white;
            end
            rwlc_pkg::CLS_RAMP:
                blue_next = (quot == 8'd0) ? 8'd1 : quot;
            rwlc_pkg::CLS_BOTTOM:
                blue_next = floor_lvl;
            rwlc_pkg::CLS_TOP, rwlc_pkg::CLS_SIDE:
                blue_next = (quot > floor_lvl) ? quot : floor_lvl;
            default:
                blue_next = 8'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red_level   = red_reg;
    assign green_level = green_reg;
    assign blue_level  = blue_reg;

endmodule

// ===== rtl/rain_wheel_led_color_core.sv =====
// Top level of the rain wheel LED color block: channels, brightness register, stage valids.
//
// Usage:
//   pixel carries one word per LED: led_index and the current hour, minute,
//   second and hundredths. color returns one word per accepted pixel word:
//   red_level, green_level and blue_level, in the same order.
//   cfg writes the brightness register; it is always ready and should only
//   be written while no pixel word is in flight.
// Timing:
//   Four register stages (input, classify, multiply, divide/output); a
//   color word moves through them in that order once its pixel word is
//   accepted, and shows on color when it reaches the output register.
//   One word per cycle is accepted and delivered for as long as color.ready
//   stays high; each stage holds one word and passes it on as the pipeline advances.
// Stall:
//   When the output word is held (color.valid high, color.ready low) the
//   whole pipeline freezes and pixel.ready drops in the same cycle; nothing
//   is lost or repeated.
// Reset:
//   rst_n clears all stage valid bits and sets brightness to 128.
`timescale 1ns / 1ps

module rain_wheel_led_color_core (
    input  logic          clk,
    input  logic          rst_n,
    rwlc_pix_if.sink      pixel,
    rwlc_color_if.source  color,
    rwlc_cfg_if.sink      cfg
);

    logic [7:0] bright_reg;
    logic [3:0] stage_valid_reg, stage_valid_next;
    logic       advance;

    // Brightness register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bright_reg <= rwlc_pkg::BRIGHT_RESET;
        else if (cfg.valid && cfg.ready)
            bright_reg <= cfg.brightness_level;
    end

    assign cfg.ready = 1'b1;

    // Pipeline moves whenever the output word is empty or being taken
    assign advance          = !stage_valid_reg[3] || color.ready;
    assign stage_valid_next = {stage_valid_reg[2:0], pixel.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 4'b0000;
        else if (advance)
            stage_valid_reg <= stage_valid_next;
    end

    assign pixel.ready = advance;
    assign color.valid = stage_valid_reg[3];

    rwlc_datapath u_datapath (
        .clk            (clk),
        .en             (advance),
        .led_index      (pixel.led_index),
        .hour_now       (pixel.hour_now),
        .minute_now     (pixel.minute_now),
        .second_now     (pixel.second_now),
        .hundredths_now (pixel.hundredths_now),
        .brightness     (bright_reg),
        .red_level      (color.red_level),
        .green_level    (color.green_level),
        .blue_level     (color.blue_level)
    );

endmodule

// ===== rtl/rwlc_checker.sv =====
// Port-level checks for the rain wheel LED color block, bound to the top level.
`timescale 1ns / 1ps

module rwlc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       pix_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] red_level,
    input logic [7:0] green_level,
    input logic [7:0] blue_level,
    input logic       cfg_ready
);

    // A held output word keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_level)
            && $stable(green_level) && $stable(blue_level))
        else $error("output word changed while stalled");

    // Input stalls exactly when the output word is stuck
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        pix_ready == (!out_valid || out_ready))
        else $error("pixel ready does not follow output stall");

    // Red and green always match; any lit red means a white LED
    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> red_level == green_level)
        else $error("red and green differ");

    a_white: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && red_level != 8'd0 |-> blue_level == red_level)
        else $error("lit red without matching blue");

    // Configuration is never refused
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config channel not ready");

endmodule

bind rain_wheel_led_color_core rwlc_checker u_rwlc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix_ready   (pixel.ready),
    .out_valid   (color.valid),
    .out_ready   (color.ready),
    .red_level   (color.red_level),
    .green_level (color.green_level),
    .blue_level  (color.blue_level),
    .cfg_ready   (cfg.ready)
);
